>>> rtl/jads_pkg.sv
// Shared constants and types for the joystick axis dead-zone scaler.
package jads_pkg;

   // Default sample width in bits.
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Configuration word format.
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Dead band register width.
   localparam int BAND_BITS = 10;

   // Position output width and full-scale deflection.
   localparam int POS_BITS   = 8;
   localparam int FULL_SCALE = 100;

   // Quotient bits; the quotient is searched below 2**QUOT_BITS, just above full scale.
   localparam int QUOT_BITS = 7;

   // Register reset values.
   localparam int MIN_RESET  = 0;
   localparam int MID_RESET  = 2048;
   localparam int MAX_RESET  = 4095;
   localparam int BAND_RESET = 40;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_LEVEL = 2'd0,
      CSR_MID_LEVEL = 2'd1,
      CSR_MAX_LEVEL = 2'd2,
      CSR_DEAD_BAND = 2'd3
   } csr_index_type;

   // Per-word flags that travel alongside the divider data.
   typedef struct packed {
      logic sample_valid;  // copy of the input sample_valid field
      logic zero;          // result is forced to zero (dead band or invalid sample)
      logic lower;         // sample lies on the lower side of the band
      logic sat;           // result saturates to the side's extreme
   } side_type;

endpackage

>>> rtl/jads_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
module jads_divider #(
   parameter int NUM_BITS = 24,
   parameter int DEN_BITS = 17
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            in_valid,
   input  jads_pkg::side_type              in_side,
   input  logic [NUM_BITS-1:0]             in_num,
   input  logic [DEN_BITS-1:0]             in_den,
   output logic                            out_valid,
   output jads_pkg::side_type              out_side,
   output logic [jads_pkg::QUOT_BITS-1:0]  out_quot
);

   localparam int QB = jads_pkg::QUOT_BITS;

   // Stage registers, one entry per quotient bit.
   logic                 valid_ff [QB];
   jads_pkg::side_type   side_ff  [QB];
   logic [NUM_BITS-1:0]  rem_ff   [QB];
   logic [DEN_BITS-1:0]  den_ff   [QB];
   logic [QB-1:0]        quot_ff  [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic                 valid_prev;
      jads_pkg::side_type   side_prev;
      logic [NUM_BITS-1:0]  rem_prev;
      logic [DEN_BITS-1:0]  den_prev;
      logic [QB-1:0]        quot_prev;
      logic [NUM_BITS-1:0]  trial;
      logic                 take;

      // The first stage takes the divider inputs, later ones the stage before.
      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign side_prev  = in_side;
         assign rem_prev   = in_num;
         assign den_prev   = in_den;
         assign quot_prev  = '0;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
      end

      // Try to subtract the divisor weighted by this stage's quotient bit.
      assign trial = NUM_BITS'(den_prev) << (QB - 1 - k);
      assign take  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[k]  <= side_prev;
            den_ff[k]   <= den_prev;
            rem_ff[k]   <= take ? (rem_prev - trial) : rem_prev;
            quot_ff[k]  <= quot_prev | (take ? (QB'(1) << (QB - 1 - k)) : QB'(0));
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_side  = side_ff[QB-1];
   assign out_quot  = quot_ff[QB-1];

endmodule

>>> rtl/joystick_axis_deadzone_scaler.sv
// Joystick axis dead-zone scaler: maps a signed sample to a deflection in percent.
// Throughput is one word per cycle while the pipeline is not held. A word passes the
// input register, band and side stage, scale stage, seven divider stages
// (one quotient bit each) and an output register on its way to the response.
// The whole pipeline holds while a response word waits and rsp_stall is high.
// Synchronous active-high reset empties the pipeline and loads the register defaults.
module joystick_axis_deadzone_scaler #(
   parameter int SAMPLE_BITS = jads_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic                                  req_sample_valid,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [jads_pkg::POS_BITS-1:0]  rsp_position,
   output logic                                  rsp_position_valid,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [jads_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [jads_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int BB       = jads_pkg::BAND_BITS;
   localparam int QB       = jads_pkg::QUOT_BITS;
   localparam int PB       = jads_pkg::POS_BITS;
   localparam int WIDE     = (SAMPLE_BITS > BB) ? SAMPLE_BITS : BB;
   localparam int EXT_BITS = WIDE + 3;
   localparam int MAG_BITS = WIDE + 1;
   localparam int NUM_BITS = MAG_BITS + QB;

   // Configuration registers.
   logic signed [SAMPLE_BITS-1:0] min_ff;
   logic signed [SAMPLE_BITS-1:0] mid_ff;
   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic [BB-1:0]                 band_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= SAMPLE_BITS'(jads_pkg::MIN_RESET);
         mid_ff  <= SAMPLE_BITS'(jads_pkg::MID_RESET);
         max_ff  <= SAMPLE_BITS'(jads_pkg::MAX_RESET);
         band_ff <= BB'(jads_pkg::BAND_RESET);
      end else if (csr_valid && csr_ready) begin
         case (jads_pkg::csr_index_type'(csr_index))
            jads_pkg::CSR_MIN_LEVEL: min_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            jads_pkg::CSR_MID_LEVEL: mid_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            jads_pkg::CSR_MAX_LEVEL: max_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            jads_pkg::CSR_DEAD_BAND: band_ff <= csr_wdata[BB-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline advances unless a finished word is held at the output.
   logic enable;
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   // Stage 0: input register.
   logic                          s0_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s0_sample_ff;
   logic                          s0_svalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_sample_ff <= req_sample;
         s0_svalid_ff <= req_sample_valid;
      end
   end

   // Stage 1: dead band test, side choice, distance from the band edge and span.
   logic signed [EXT_BITS-1:0] s_x;
   logic signed [EXT_BITS-1:0] mid_x;
   logic signed [EXT_BITS-1:0] min_x;
   logic signed [EXT_BITS-1:0] max_x;
   logic signed [EXT_BITS-1:0] band_x;
   logic signed [EXT_BITS-1:0] diff_x;
   logic signed [EXT_BITS-1:0] abs_x;
   logic signed [EXT_BITS-1:0] lo_x;
   logic signed [EXT_BITS-1:0] hi_x;
   logic signed [EXT_BITS-1:0] dist_x;
   logic signed [EXT_BITS-1:0] span_x;
   logic                       dead;
   logic                       lower;

   always_comb begin
      s_x    = {{(EXT_BITS-SAMPLE_BITS){s0_sample_ff[SAMPLE_BITS-1]}}, s0_sample_ff};
      mid_x  = {{(EXT_BITS-SAMPLE_BITS){mid_ff[SAMPLE_BITS-1]}}, mid_ff};
      min_x  = {{(EXT_BITS-SAMPLE_BITS){min_ff[SAMPLE_BITS-1]}}, min_ff};
      max_x  = {{(EXT_BITS-SAMPLE_BITS){max_ff[SAMPLE_BITS-1]}}, max_ff};
      band_x = {{(EXT_BITS-BB){1'b0}}, band_ff};
      diff_x = s_x - mid_x;
      abs_x  = (diff_x < 0) ? -diff_x : diff_x;
      dead   = abs_x < band_x;
      lo_x   = mid_x - band_x;
      hi_x   = mid_x + band_x;
      lower  = s_x <= lo_x;
      dist_x = lower ? (lo_x - s_x) : (s_x - hi_x);
      span_x = lower ? (lo_x - min_x) : (max_x - hi_x);
   end

   logic                       s1_valid_ff;
   logic                       s1_svalid_ff;
   logic                       s1_zero_ff;
   logic                       s1_lower_ff;
   logic [MAG_BITS-1:0]        s1_dist_ff;
   logic signed [EXT_BITS-1:0] s1_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_svalid_ff <= s0_svalid_ff;
         s1_zero_ff   <= dead || !s0_svalid_ff;
         s1_lower_ff  <= lower;
         s1_dist_ff   <= dist_x[MAG_BITS-1:0];
         s1_span_ff   <= span_x;
      end
   end

   // Stage 2: scale the distance to percent and detect saturation.
   logic [NUM_BITS-1:0] num;
   logic [MAG_BITS-1:0] span_mag;
   logic                sat;

   always_comb begin
      num      = NUM_BITS'(s1_dist_ff) * NUM_BITS'(jads_pkg::FULL_SCALE);
      span_mag = s1_span_ff[MAG_BITS-1:0];
      sat      = (s1_span_ff <= 0) || (num >= (NUM_BITS'(span_mag) << QB));
   end

   logic                s2_valid_ff;
   jads_pkg::side_type  s2_side_ff;
   logic [NUM_BITS-1:0] s2_num_ff;
   logic [MAG_BITS-1:0] s2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_side_ff.sample_valid <= s1_svalid_ff;
         s2_side_ff.zero         <= s1_zero_ff;
         s2_side_ff.lower        <= s1_lower_ff;
         s2_side_ff.sat          <= sat;
         s2_num_ff               <= num;
         s2_den_ff               <= span_mag;
      end
   end

   // Stages 3 to 9: quotient, one bit per stage.
   logic               div_valid;
   jads_pkg::side_type div_side;
   logic [QB-1:0]      div_quot;

   jads_divider #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (MAG_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (s2_valid_ff),
      .in_side   (s2_side_ff),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quot  (div_quot)
   );

   // Output stage: clamp, apply the side's sign and register the word.
   logic [QB-1:0]        mag;
   logic signed [PB-1:0] mag_s;
   logic signed [PB-1:0] position_in;

   always_comb begin
      if (div_side.sat || (div_quot > QB'(jads_pkg::FULL_SCALE))) begin
         mag = QB'(jads_pkg::FULL_SCALE);
      end else begin
         mag = div_quot;
      end
      mag_s = PB'(mag);
      if (div_side.zero) begin
         position_in = '0;
      end else if (div_side.lower) begin
         position_in = -mag_s;
      end else begin
         position_in = mag_s;
      end
   end

   logic                 rsp_valid_ff;
   logic signed [PB-1:0] rsp_position_ff;
   logic                 rsp_position_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_position_ff       <= position_in;
         rsp_position_valid_ff <= div_side.sample_valid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_position_valid = rsp_position_valid_ff;

endmodule
